/* rtl/lgfb_pkg.sv */
package lgfb_pkg;

	localparam int LED_COUNT   = 16;
	localparam int FRAME_BYTES = 97;
	localparam int WORD_COUNT  = 13;
	localparam int WORD_BITS   = 64;
	localparam int FRAME_BITS  = WORD_COUNT * WORD_BITS;
	localparam int MAIN_FIRST  = 3;
	localparam int MAIN_MAX    = LED_COUNT - MAIN_FIRST;

	localparam logic [1:0] KIND_WRITE_MASKED = 2'd0;
	localparam logic [1:0] KIND_SET_MASKED   = 2'd1;
	localparam logic [1:0] KIND_MAIN_ROW     = 2'd2;

	localparam logic [3:0] MAIN_ROW_RESET = 4'd9;
	localparam logic [3:0] LAST_WORD_IDX  = 4'(WORD_COUNT - 1);
	localparam logic [3:0] FULL_BYTES     = 4'd8;
	localparam logic [3:0] TAIL_BYTES     = 4'(FRAME_BYTES - (WORD_COUNT - 1) * 8);

	// led shown in each frame slot
	localparam logic [3:0] SLOT_LED [LED_COUNT] = '{
		4'd12, 4'd11, 4'd10, 4'd5, 4'd13, 4'd14, 4'd2, 4'd0,
		4'd9, 4'd7, 4'd1, 4'd3, 4'd8, 4'd6, 4'd15, 4'd4
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [47:0] color;
		logic [15:0] led_mask;
	} update_t;

	typedef struct packed {
		logic [63:0] frame_word;
		logic [3:0]  valid_bytes;
		logic        last_word;
	} result_t;

	typedef struct packed {
		logic apply;
		logic load;
		logic shift;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage

/* rtl/lgfb_datapath.sv */
module lgfb_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [3:0]        cfg_data,
	input  lgfb_pkg::update_t update,
	input  lgfb_pkg::cmd_t    cmd,
	output lgfb_pkg::status_t status,
	output lgfb_pkg::result_t result
);
	import lgfb_pkg::*;

	logic [47:0]           color_q [LED_COUNT];
	logic [3:0]            main_row_count_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [3:0]            word_position_q;
	logic [FRAME_BITS-1:0] frame_d;
	logic [3:0]            row_cnt;
	logic [LED_COUNT-1:0]  row_sel;

	function automatic logic [7:0] rev8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

	// saturate the main row length
	assign row_cnt = (main_row_count_q > 4'(MAIN_MAX)) ? 4'(MAIN_MAX) : main_row_count_q;

	always_comb begin
		for (int n = 0; n < LED_COUNT; n++) begin
			row_sel[n] = (n >= MAIN_FIRST) && (5'(n - MAIN_FIRST) < {1'b0, row_cnt});
		end
	end

	// frame layout: zero lead byte, then six bit-reversed bytes per slot, low byte first
	always_comb begin
		frame_d = '0;
		for (int s = 0; s < LED_COUNT; s++) begin
			for (int k = 0; k < 6; k++) begin
				frame_d[FRAME_BITS-1-8*(1+6*s+k) -: 8] = rev8(color_q[SLOT_LED[s]][8*k +: 8]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < LED_COUNT; n++) begin
				color_q[n] <= '0;
			end
			main_row_count_q <= MAIN_ROW_RESET;
			word_position_q  <= '0;
		end else begin
			if (cfg_valid) begin
				main_row_count_q <= cfg_data;
			end
			if (cmd.apply) begin
				unique case (update.kind)
					KIND_WRITE_MASKED: begin
						for (int n = 0; n < LED_COUNT; n++) begin
							color_q[n] <= update.led_mask[n] ? update.color : '0;
						end
					end
					KIND_SET_MASKED: begin
						for (int n = 0; n < LED_COUNT; n++) begin
							if (update.led_mask[n]) begin
								color_q[n] <= update.color;
							end
						end
					end
					KIND_MAIN_ROW: begin
						for (int n = 0; n < LED_COUNT; n++) begin
							if (row_sel[n]) begin
								color_q[n] <= update.color;
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				word_position_q <= '0;
			end else if (cmd.shift) begin
				word_position_q <= word_position_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			frame_q <= frame_d;
		end else if (cmd.shift) begin
			frame_q <= frame_q << WORD_BITS;
		end
	end

	assign status.last        = (word_position_q == LAST_WORD_IDX);
	assign result.frame_word  = frame_q[FRAME_BITS-1 -: WORD_BITS];
	assign result.last_word   = status.last;
	assign result.valid_bytes = status.last ? TAIL_BYTES : FULL_BYTES;

endmodule

/* rtl/lgfb_ctrl.sv */
module lgfb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lgfb_pkg::status_t status,
	output lgfb_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              result_valid
);
	import lgfb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			emit_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOAD;
						busy_q  <= 1'b1;
					end
				end
				ST_LOAD: begin
					state_q <= ST_EMIT;
					emit_q  <= 1'b1;
				end
				ST_EMIT: begin
					if (status.last) begin
						state_q <= ST_IDLE;
						emit_q  <= 1'b0;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					emit_q  <= 1'b0;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign cmd.apply    = start && !busy_q;
	assign cmd.load     = (state_q == ST_LOAD);
	assign cmd.shift    = emit_q;
	assign busy         = busy_q;
	assign result_valid = emit_q;

endmodule

/* rtl/led_grayscale_frame_builder.sv */
// channel   | signals                       | handshake
// ----------+-------------------------------+-------------------------------------
// update    | start, busy, update           | item taken when start && !busy
// result    | result_valid, result          | one-cycle strobe, no back-pressure
// config    | cfg_valid, cfg_ready, cfg_data| written when cfg_valid && cfg_ready
//
// every item goes in three steps: the update is applied to the color registers,
// the frame is laid into the 832-bit frame register, then 13 words, one per
// cycle, are shifted out of that register; busy is high for the last two steps
// reset clears all colors to zero and sets main_row_count to 9; no clearing pass
// results cannot be stalled: each word is on the result port for one cycle only
// cfg_ready is always high; the user makes writes only while busy is low, the block does not enforce it
module led_grayscale_frame_builder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lgfb_pkg::update_t update,
	output logic              result_valid,
	output lgfb_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_data
);
	import lgfb_pkg::*;

	// command and status between sequencer and datapath
	cmd_t    cmd;
	status_t status;

	// register port never pushes back
	assign cfg_ready = 1'b1;

	// sequencer: idle, frame load, word emission
	lgfb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	// color registers, frame register and word counter
	lgfb_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.update    (update),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

/* rtl/lgfb_checker.sv */
module lgfb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              result_valid,
	input lgfb_pkg::result_t result
);
	import lgfb_pkg::*;

	// a word only goes out while an item is in flight
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe while idle");

	// taking an item raises busy on the next cycle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an item was taken");

	// the load state sits between the item and its first word
	a_load_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_valid)
		else $error("word emitted in the load cycle");

	// the final word releases the block
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_word) |=> !busy)
		else $error("busy held after the final word");

	// the final word carries one byte and other words carry eight
	a_last_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last_word ? (result.valid_bytes == TAIL_BYTES)
			: (result.valid_bytes == FULL_BYTES)))
		else $error("byte count does not match word position");

endmodule

bind led_grayscale_frame_builder lgfb_checker u_lgfb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
